// ===== hw/rtl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam int unsigned KeyBits    = 32;
  localparam int unsigned HandleBits = 16;
  localparam int unsigned CountBits  = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PRUNE  = 2'd2,
    ACT_FLUSH  = 2'd3
  } spq_action_e;

  typedef struct packed {
    spq_action_e                 action;
    logic signed [KeyBits-1:0]   key;
    logic [HandleBits-1:0]       handle;
  } spq_in_t;

  typedef struct packed {
    logic                        head_valid;
    logic signed [KeyBits-1:0]   head_key;
    logic [HandleBits-1:0]       head_handle;
    logic                        popped_valid;
    logic [HandleBits-1:0]       popped_handle;
    logic [CountBits-1:0]        entry_count;
    logic                        overflow;
  } spq_out_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic                        en;
    spq_action_e                 action;
    logic signed [KeyBits-1:0]   key;
    logic [HandleBits-1:0]       handle;
  } spq_op_t;

endpackage

// ===== hw/rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell chain, result stage and handshakes.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (spq_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (spq_out_t)
//
// In the accept cycle every cell of the chain updates in parallel; after that,
// once the output register is free, the head and the count are read off
// the chain into the output register. The result stage decides the rate.
// Reset clears all cell valid bits and the handshake state; cell payloads are
// left as they are. A stalled output holds the result and keeps the next
// request waiting in the result stage, which in turn holds in_ready_o low.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  spq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spq_out_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                      valid_w  [DEPTH];
  logic signed [KeyBits-1:0] key_w    [DEPTH];
  logic [HANDLE_BITS-1:0]    handle_w [DEPTH];
  logic                      after_w  [DEPTH];

  logic     accept;
  logic     full;
  spq_op_t  op;

  logic                  pend_q;
  logic                  popped_valid_q, popped_valid_d;
  logic [HandleBits-1:0] popped_handle_q, popped_handle_d;
  logic                  overflow_q, overflow_d;
  logic                  out_valid_q;
  spq_out_t              out_data_q, out_data_d;
  logic                  load_out;
  logic [CntW-1:0]       count;

  // Accept one request at a time; hold off while the result is in flight.
  assign in_ready_o = !pend_q;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = valid_w[DEPTH-1];

  // Drop an insert into a full queue: the chain sees no operation.
  always_comb begin
    op.en     = accept && !((in_data_i.action == ACT_INSERT) && full);
    op.action = in_data_i.action;
    op.key    = in_data_i.key;
    op.handle = in_data_i.handle;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      lv, rv, la;
    logic signed [KeyBits-1:0] lk, rk;
    logic [HANDLE_BITS-1:0]    lh, rh;

    // The head cell sees a virtual left neighbor that always keeps its place.
    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign lk = in_data_i.key;
      assign lh = HANDLE_BITS'(in_data_i.handle);
      assign la = 1'b1;
    end else begin : g_mid
      assign lv = valid_w[i-1];
      assign lk = key_w[i-1];
      assign lh = handle_w[i-1];
      assign la = after_w[i-1];
    end

    // The tail cell pulls in an empty slot on pop.
    if (i == DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rk = key_w[i];
      assign rh = handle_w[i];
    end else begin : g_body
      assign rv = valid_w[i+1];
      assign rk = key_w[i+1];
      assign rh = handle_w[i+1];
    end

    spq_cell #(
      .HANDLE_BITS(HANDLE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (op),
      .left_valid_i  (lv),
      .left_key_i    (lk),
      .left_handle_i (lh),
      .left_after_i  (la),
      .right_valid_i (rv),
      .right_key_i   (rk),
      .right_handle_i(rh),
      .valid_o       (valid_w[i]),
      .key_o         (key_w[i]),
      .handle_o      (handle_w[i]),
      .after_o       (after_w[i])
    );
  end

  // Capture the per-request flags that depend on the chain before the update.
  always_comb begin
    popped_valid_d  = popped_valid_q;
    popped_handle_d = popped_handle_q;
    overflow_d      = overflow_q;
    if (accept) begin
      popped_valid_d  = (in_data_i.action == ACT_POP) && valid_w[0];
      popped_handle_d = popped_valid_d ? HandleBits'(handle_w[0]) : '0;
      overflow_d      = (in_data_i.action == ACT_INSERT) && full;
    end
  end

  // Valid bits form a thermometer; the count is the index past its last one.
  always_comb begin
    count = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (valid_w[i] && ((i == DEPTH - 1) || !valid_w[(i + 1) % DEPTH])) begin
        count = count | CntW'(i + 1);
      end
    end
  end

  assign load_out = pend_q && (!out_valid_q || out_ready_i);

  always_comb begin
    out_data_d.head_valid    = valid_w[0];
    out_data_d.head_key      = valid_w[0] ? key_w[0] : '0;
    out_data_d.head_handle   = valid_w[0] ? HandleBits'(handle_w[0]) : '0;
    out_data_d.popped_valid  = popped_valid_q;
    out_data_d.popped_handle = popped_handle_q;
    out_data_d.entry_count   = CountBits'(count);
    out_data_d.overflow      = overflow_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pend_q <= 1'b1;
      end else if (load_out) begin
        pend_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    popped_valid_q  <= popped_valid_d;
    popped_handle_q <= popped_handle_d;
    overflow_q      <= overflow_d;
    if (load_out) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/spq_cell.sv =====
// One cell of the queue chain: holds one entry and trades it with its neighbors.
module spq_cell import spq_pkg::*; #(
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  spq_op_t                  op_i,
  input  logic                     left_valid_i,
  input  logic signed [KeyBits-1:0] left_key_i,
  input  logic [HANDLE_BITS-1:0]   left_handle_i,
  input  logic                     left_after_i,
  input  logic                     right_valid_i,
  input  logic signed [KeyBits-1:0] right_key_i,
  input  logic [HANDLE_BITS-1:0]   right_handle_i,
  output logic                     valid_o,
  output logic signed [KeyBits-1:0] key_o,
  output logic [HANDLE_BITS-1:0]   handle_o,
  output logic                     after_o
);

  logic                      valid_q, valid_d;
  logic signed [KeyBits-1:0] key_q, key_d;
  logic [HANDLE_BITS-1:0]    handle_q, handle_d;

  // The new entry goes behind this cell when this cell holds a smaller key.
  assign after_o = valid_q && (key_q < op_i.key);

  always_comb begin
    valid_d  = valid_q;
    key_d    = key_q;
    handle_d = handle_q;
    if (op_i.en) begin
      unique case (op_i.action)
        ACT_INSERT: begin
          valid_d = valid_q | left_valid_i;
          if (!after_o) begin
            if (left_after_i) begin
              key_d    = op_i.key;
              handle_d = HANDLE_BITS'(op_i.handle);
            end else begin
              key_d    = left_key_i;
              handle_d = left_handle_i;
            end
          end
        end
        ACT_POP: begin
          valid_d  = right_valid_i;
          key_d    = right_key_i;
          handle_d = right_handle_i;
        end
        ACT_PRUNE: valid_d = valid_q && !(key_q > op_i.key);
        ACT_FLUSH: valid_d = 1'b0;
        default:   valid_d = valid_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign valid_o  = valid_q;
  assign key_o    = key_q;
  assign handle_o = handle_q;

endmodule
